### src/nnip_pkg.sv
package nnip_pkg;

  localparam int MAX_COORDS_DEF  = 4096;
  localparam int MAX_HISTORY_DEF = 16;
  localparam int VALUE_BITS_DEF  = 24;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_ADDR_W-1:0] REG_HISTORY = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COORDS  = 2'd2;

  localparam logic [4:0]  HIST_RESET   = 5'd8;
  localparam logic [3:0]  WINDOW_RESET = 4'd2;
  localparam logic [12:0] COORDS_RESET = 13'd4096;

  // Distance accumulator width: 2*28 plus 7 bits of growth, enough for up to 128 terms.
  localparam int DIST_W = 2 * 28 + 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACC,
    ST_CMP,
    ST_PRED,
    ST_WRITE,
    ST_OUT
  } bk_state_t;

endpackage

### src/nearest_neighbour_interframe_predictor_core.sv
// Raw words pass from accept to output through the back end's WRITE and OUT
// states; residual words first run the window search, whose length is set by
// the one-read history memory. The back end takes one word at a time and
// starts the next word only once its output register is empty; a two-word
// queue lets the front accept while the back end works.
// Reset (synchronous, active low) clears counters and the history ring
// position; history memory contents are not cleared.
module nearest_neighbour_interframe_predictor_core
  import nnip_pkg::*;
#(
  parameter int MAX_COORDS  = MAX_COORDS_DEF,
  parameter int MAX_HISTORY = MAX_HISTORY_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_BITS-1:0]  in_coord_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_is_residual,
  output logic signed [VALUE_BITS:0] out_coded_value,
  output logic [11:0]            out_coord_index,
  output logic                   out_frame_last
);

  localparam int IDX_W  = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1;
  localparam int KW     = $clog2(MAX_HISTORY + 1);
  localparam int SLOT_W = $clog2(MAX_HISTORY);

  logic [4:0]  hist_r;
  logic [3:0]  win_r;
  logic [12:0] coords_r;
  logic        restart;
  logic [KW-1:0]  k_eff, v_eff;
  logic [IDX_W:0] n_eff;

  logic                  q_valid, q_ready, q_last, q_resid;
  logic [VALUE_BITS-1:0] q_value;
  logic [IDX_W-1:0]      q_idx;
  logic [SLOT_W-1:0]     q_wslot;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= HIST_RESET; win_r <= WINDOW_RESET; coords_r <= COORDS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HISTORY: hist_r <= cfg_data[4:0];
        REG_WINDOW:  win_r <= cfg_data[3:0];
        REG_COORDS:  coords_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign restart = cfg_we && (cfg_index == REG_HISTORY || cfg_index == REG_COORDS);

  // Saturate the registers into their legal ranges.
  always_comb begin
    if (hist_r < 5'd3) k_eff = KW'(3);
    else if (32'(hist_r) > MAX_HISTORY) k_eff = KW'(MAX_HISTORY);
    else k_eff = KW'(hist_r);
    if (win_r == 4'd0) v_eff = KW'(1);
    else if (32'(win_r) > 32'(k_eff) - 2) v_eff = k_eff - KW'(2);
    else v_eff = KW'(win_r);
    if (coords_r == 13'd0) n_eff = (IDX_W+1)'(1);
    else if (32'(coords_r) > MAX_COORDS) n_eff = (IDX_W+1)'(MAX_COORDS);
    else n_eff = (IDX_W+1)'(coords_r);
  end

  nnip_front #(.MAX_COORDS(MAX_COORDS), .MAX_HISTORY(MAX_HISTORY),
               .VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst_n, .restart, .k_eff, .n_eff,
    .in_valid, .in_ready, .in_coord_value,
    .q_valid, .q_ready, .q_value, .q_idx, .q_last, .q_resid, .q_wslot
  );

  nnip_back #(.MAX_COORDS(MAX_COORDS), .MAX_HISTORY(MAX_HISTORY),
              .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst_n, .restart, .k_eff, .v_eff,
    .q_valid, .q_ready, .q_value, .q_idx, .q_last, .q_resid, .q_wslot,
    .out_valid, .out_ready, .out_is_residual, .out_coded_value,
    .out_coord_index, .out_frame_last
  );

  // The queue pops only when the back end has a free output register.
  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> !out_valid) else $error("pop with full output");

  // A pop always produces a word on the next cycle.
  a_pop_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_ready |=> out_valid) else $error("pop lost");

  // Every result carries an index below the frame size.
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_coord_index} < n_eff) else $error("index range");

endmodule

### src/nnip_front.sv
// Front end: counts positions in the frame, picks the frame mode and pushes
// one classified word per input into a small queue.
module nnip_front
  import nnip_pkg::*;
#(
  parameter int MAX_COORDS  = MAX_COORDS_DEF,
  parameter int MAX_HISTORY = MAX_HISTORY_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF,
  parameter int IDX_W       = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1,
  parameter int KW          = $clog2(MAX_HISTORY + 1),
  parameter int SLOT_W      = $clog2(MAX_HISTORY)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  restart,
  input  logic [KW-1:0]         k_eff,
  input  logic [IDX_W:0]        n_eff,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_coord_value,
  output logic                  q_valid,
  input  logic                  q_ready,
  output logic [VALUE_BITS-1:0] q_value,
  output logic [IDX_W-1:0]      q_idx,
  output logic                  q_last,
  output logic                  q_resid,
  output logic [SLOT_W-1:0]     q_wslot
);

  logic [IDX_W:0]      coord_counter_r, coord_counter_nxt;
  logic [KW-1:0]       frames_stored_r, frames_stored_nxt;
  logic                mode_r, mode_nxt;
  logic [SLOT_W-1:0]   fill_slot_r, fill_slot_nxt;
  logic [IDX_W:0]      idx;
  logic                last;
  logic                fire;

  // Two-entry queue toward the back end.
  localparam int QW = VALUE_BITS + IDX_W + 2 + SLOT_W;
  logic [QW-1:0] q_mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic [QW-1:0] push_word;

  assign in_ready = (cnt_r != 2'd2);
  assign fire     = in_valid && in_ready;

  always_comb begin
    idx = (coord_counter_r >= n_eff) ? n_eff - 1'b1 : coord_counter_r;
    last = ({1'b0, idx} + 1'b1 >= {1'b0, n_eff});
    mode_nxt = (idx == '0) ? (frames_stored_r >= k_eff) : mode_r;
    coord_counter_nxt = last ? '0 : idx + 1'b1;
    frames_stored_nxt = frames_stored_r;
    fill_slot_nxt = fill_slot_r;
    if (last && !mode_nxt && frames_stored_r < k_eff) begin
      frames_stored_nxt = frames_stored_r + 1'b1;
      fill_slot_nxt = fill_slot_r + 1'b1;
    end
  end

  // During fill the write slot is the frame count; in residual mode the
  // back end uses its own oldest slot.
  assign push_word = {in_coord_value, idx[IDX_W-1:0], last, mode_nxt, fill_slot_r};

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      coord_counter_r <= '0;
      frames_stored_r <= '0;
      mode_r <= 1'b0;
      fill_slot_r <= '0;
    end else if (fire) begin
      coord_counter_r <= coord_counter_nxt;
      frames_stored_r <= frames_stored_nxt;
      mode_r <= mode_nxt;
      fill_slot_r <= fill_slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (fire) wp_r <= ~wp_r;
      if (q_valid && q_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, fire} - {1'b0, q_valid && q_ready};
    end
  end

  always_ff @(posedge clk) begin
    if (fire) q_mem_r[wp_r] <= push_word;
  end

  assign q_valid = (cnt_r != 2'd0);
  assign {q_value, q_idx, q_last, q_resid, q_wslot} = q_mem_r[rp_r];

endmodule

### src/nnip_back.sv
// Back end: runs the window search over the history memory for residual
// words, writes the new value back and holds the result in an output register.
module nnip_back
  import nnip_pkg::*;
#(
  parameter int MAX_COORDS  = MAX_COORDS_DEF,
  parameter int MAX_HISTORY = MAX_HISTORY_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF,
  parameter int IDX_W       = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1,
  parameter int KW          = $clog2(MAX_HISTORY + 1),
  parameter int SLOT_W      = $clog2(MAX_HISTORY)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  restart,
  input  logic [KW-1:0]         k_eff,
  input  logic [KW-1:0]         v_eff,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic [VALUE_BITS-1:0] q_value,
  input  logic [IDX_W-1:0]      q_idx,
  input  logic                  q_last,
  input  logic                  q_resid,
  input  logic [SLOT_W-1:0]     q_wslot,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_is_residual,
  output logic signed [VALUE_BITS:0] out_coded_value,
  output logic [11:0]           out_coord_index,
  output logic                  out_frame_last
);

  localparam int AW = SLOT_W + IDX_W;

  bk_state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0] mem [2**AW];
  logic [VALUE_BITS-1:0] rd_r;
  logic [AW-1:0]         raddr, waddr;
  logic                  we;

  logic [SLOT_W-1:0] oldest_r;
  logic [KW-1:0]     j_r, t_r, best_r;
  logic              phase_r;      // 0 reads window value, 1 reads pattern value
  logic [VALUE_BITS-1:0] a_r;
  logic [2*VALUE_BITS-1:0] sq_r;
  logic [DIST_W-1:0] d_r, best_d_r;
  logic              best_ok_r;
  logic              sq_pend_r;
  logic              rd_pend_r;
  logic [KW-1:0]     rel;
  logic [KW:0]       slot_sum;
  logic [SLOT_W-1:0] slot;
  logic [VALUE_BITS-1:0] diff;
  logic              acc_done;

  // Frame t relative to oldest, folded into the ring of k_eff slots. The read
  // data is registered in rd_r, so each cycle requests the value that the
  // next cycle consumes.
  always_comb begin
    if (state_r == ST_PRED) rel = best_r + v_eff;
    else if (state_r == ST_SCAN) rel = j_r;
    else if (!phase_r) rel = k_eff - v_eff + t_r;
    else rel = j_r + t_r + 1'b1;
    slot_sum = {1'b0, rel} + {{(KW+1-SLOT_W){1'b0}}, oldest_r};
    if (slot_sum >= {1'b0, k_eff}) slot_sum = slot_sum - {1'b0, k_eff};
    slot = slot_sum[SLOT_W-1:0];
  end

  assign raddr = {slot, q_idx};
  assign waddr = {q_resid ? oldest_r : q_wslot, q_idx};
  assign we    = (state_r == ST_WRITE);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= q_value;
    rd_r <= mem[raddr];
  end

  assign diff = (a_r > rd_r) ? a_r - rd_r : rd_r - a_r;
  assign acc_done = (t_r == v_eff) && !rd_pend_r && !sq_pend_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (q_valid && !out_valid) state_nxt = q_resid ? ST_SCAN : ST_WRITE;
      ST_SCAN:  state_nxt = ST_ACC;
      ST_ACC:   if (acc_done) state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ({1'b0, j_r} + {1'b0, v_eff} + (KW+1)'(2) >= {1'b0, k_eff})
                            ? ST_PRED : ST_SCAN;
      ST_PRED:  state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_ready = (state_r == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // Scan datapath: each term reads window, then pattern, then squares.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        j_r <= '0; best_r <= '0; best_ok_r <= 1'b0;
      end
      ST_SCAN: begin
        t_r <= '0; phase_r <= 1'b0; d_r <= '0;
        rd_pend_r <= 1'b1; sq_pend_r <= 1'b0;
      end
      ST_ACC: begin
        if (sq_pend_r) d_r <= d_r + DIST_W'(sq_r);
        sq_pend_r <= rd_pend_r && phase_r;
        if (rd_pend_r) begin
          if (!phase_r) begin
            a_r <= rd_r; phase_r <= 1'b1;
          end else begin
            sq_r <= diff * diff;
            phase_r <= 1'b0; t_r <= t_r + 1'b1;
            if (t_r + 1'b1 == v_eff) rd_pend_r <= 1'b0;
          end
        end
      end
      ST_CMP: begin
        if (!best_ok_r || d_r < best_d_r) begin
          best_d_r <= d_r; best_r <= j_r; best_ok_r <= 1'b1;
        end
        j_r <= j_r + 1'b1;
      end
      default: ;
    endcase
  end

  // Ring position of the oldest frame.
  always_ff @(posedge clk) begin
    if (!rst_n || restart) oldest_r <= '0;
    else if (state_r == ST_OUT && q_resid && q_last)
      oldest_r <= ((KW+1)'(oldest_r) + 1'b1 >= {1'b0, k_eff})
                  ? '0 : oldest_r + 1'b1;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (state_r == ST_OUT) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WRITE) begin
      out_is_residual <= q_resid;
      out_coded_value <= q_resid ? $signed({1'b0, rd_r} - {1'b0, q_value})
                                 : $signed({1'b0, q_value});
      out_coord_index <= 12'(q_idx);
      out_frame_last  <= q_last;
    end
  end

endmodule

### dv/tb_nearest_neighbour_interframe_predictor_core.sv
module tb_nearest_neighbour_interframe_predictor_core;
  import nnip_pkg::*;

  localparam int VB = VALUE_BITS_DEF;
  localparam int MAXC = MAX_COORDS_DEF;
  localparam int MAXH = MAX_HISTORY_DEF;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic               is_residual;
    logic [VB:0]        coded_value;
    logic [11:0]        coord_index;
    logic               frame_last;
  } coded_word_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [VB-1:0]     in_coord_value;
  logic              out_valid;
  logic              out_ready;
  logic              out_is_residual;
  logic signed [VB:0] out_coded_value;
  logic [11:0]       out_coord_index;
  logic              out_frame_last;

  nearest_neighbour_interframe_predictor_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_coord_value(in_coord_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_is_residual(out_is_residual), .out_coded_value(out_coded_value),
    .out_coord_index(out_coord_index), .out_frame_last(out_frame_last)
  );

  // Predictor state, kept apart from the block.
  logic [VB-1:0] hist_mem [MAXH*MAXC];
  int unsigned   ring_oldest;
  int unsigned   frames_kept;
  int unsigned   coord_pos;
  bit            mode_residual;
  int unsigned   hist_reg;
  int unsigned   win_reg;
  int unsigned   coords_reg;

  coded_word_t   expected_words[$];
  int            mismatches;
  int            cycle_count;
  int            send_idle_pct;
  int            recv_idle_pct;
  bit            hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned hist_at(int unsigned t, int unsigned k, int unsigned idx);
    return hist_mem[((ring_oldest + t) % k) * MAXC + idx];
  endfunction

  function automatic void restart_prediction();
    ring_oldest = 0;
    frames_kept = 0;
    coord_pos = 0;
    mode_residual = 1'b0;
  endfunction

  // Works out the coded word for one coordinate and updates the history.
  function automatic coded_word_t code_coordinate(logic [VB-1:0] x);
    coded_word_t w;
    int unsigned k, v, n, idx, best, wslot, pred;
    longint unsigned best_d, d, a, b, diff;
    k = hist_reg < 3 ? 3 : (hist_reg > MAXH ? MAXH : hist_reg);
    v = win_reg < 1 ? 1 : win_reg;
    if (v > k - 2) v = k - 2;
    n = coords_reg < 1 ? 1 : (coords_reg > MAXC ? MAXC : coords_reg);
    idx = coord_pos;
    if (idx >= n) idx = n - 1;
    if (idx == 0) mode_residual = (frames_kept >= k);
    w.frame_last = (idx + 1 >= n);
    if (mode_residual) begin
      best = 0;
      best_d = 64'd1 << 60;
      for (int unsigned j = 0; j + v + 1 < k; j++) begin
        d = 0;
        for (int unsigned t = 0; t < v; t++) begin
          a = hist_at(j + t, k, idx);
          b = hist_at(k - v + t, k, idx);
          diff = a > b ? a - b : b - a;
          d += diff * diff;
        end
        if (d < best_d) begin
          best_d = d;
          best = j;
        end
      end
      pred = hist_at(best + v, k, idx);
      w.coded_value = (VB+1)'(pred - x);
      wslot = ring_oldest % k;
    end else begin
      w.coded_value = {1'b0, x};
      wslot = (ring_oldest + frames_kept) % k;
    end
    hist_mem[wslot * MAXC + idx] = x;
    w.is_residual = mode_residual;
    w.coord_index = idx[11:0];
    if (w.frame_last) begin
      if (mode_residual) ring_oldest = (ring_oldest + 1) % k;
      else if (frames_kept < k) frames_kept++;
      coord_pos = 0;
    end else begin
      coord_pos = idx + 1;
    end
    return w;
  endfunction

  // Sends one word and records its expected coded word. Valid drops only
  // when the sender idles; drain() drops it after the last word.
  task automatic send_coord(logic [VB-1:0] x);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_coord_value <= x;
    expected_words.insert(expected_words.size(), code_coordinate(x));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Waits for every expected word, plus the residual latency margin.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HISTORY) begin
      hist_reg = val & 32'h1F;
      restart_prediction();
    end else if (idx == REG_WINDOW) begin
      win_reg = val & 32'hF;
    end else if (idx == REG_COORDS) begin
      coords_reg = val & 32'h1FFF;
      restart_prediction();
    end
    @(posedge clk);
  endtask

  // Smooth trajectories so the window search meets real structure; wild sends random values.
  task automatic send_frames(int frames, int unsigned n, bit wild);
    logic [VB-1:0] base [MAXC];
    for (int unsigned i = 0; i < n; i++) base[i] = $urandom();
    for (int f = 0; f < frames; f++) begin
      for (int unsigned i = 0; i < n; i++) begin
        if (wild || $urandom_range(9) == 0) base[i] = $urandom();
        else base[i] = base[i] + VB'($urandom_range(8)) - VB'(4);
        send_coord(base[i]);
      end
    end
  endtask

  task automatic test_directed();
    write_reg(REG_HISTORY, 3);
    write_reg(REG_WINDOW, 1);
    write_reg(REG_COORDS, 2);
    send_coord('0);
    send_coord('1);
    send_coord(24'h800000);
    send_coord(24'h7FFFFF);
    send_coord(24'h555555);
    send_coord(24'hAAAAAA);
    send_coord('1);
    send_coord('0);
    send_coord('0);
    send_coord('1);
    // Equal values; a history of three leaves a single window start, so no tie arises.
    send_coord(24'h10);
    send_coord(24'h10);
    send_coord(24'h10);
    send_coord(24'h10);
    drain();
    // A window write of zero saturates to one and causes no restart.
    write_reg(REG_WINDOW, 0);
    send_coord(24'h123456);
    send_coord(24'hFEDCBA);
    drain();
    // Out-of-range settings saturate.
    write_reg(REG_HISTORY, 31);
    write_reg(REG_WINDOW, 15);
    write_reg(REG_COORDS, 0);
    send_frames(19, 1, 1'b1);
    drain();
  endtask

  task automatic test_random(int phase);
    int unsigned k, n;
    for (int r = 0; r < 3; r++) begin
      k = $urandom_range(3, 16);
      n = $urandom_range(1, 6);
      if (r == 0 && phase == 0) begin
        k = 16;
        n = 3;
      end
      write_reg(REG_HISTORY, (r == 1 && phase == 1) ? 2 : k);
      write_reg(REG_WINDOW, $urandom_range(0, 15));
      write_reg(REG_COORDS, n);
      send_frames(k + 4, n, $urandom_range(3) == 0);
      if (phase == 2 && r == 0) begin
        drain();
        write_reg(REG_WINDOW, $urandom_range(1, 14));
        send_frames(2, n, 1'b0);
      end
      drain();
    end
  endtask

  task automatic test_large_frame();
    write_reg(REG_COORDS, 4096);
    write_reg(REG_HISTORY, 3);
    write_reg(REG_WINDOW, 1);
    // Part of a full-size frame; the next size write restarts the history.
    send_frames(1, 600, 1'b1);
    drain();
    write_reg(REG_COORDS, 5000);
    send_frames(1, 5, 1'b1);
    drain();
  endtask

  task automatic test_backpressure();
    write_reg(REG_HISTORY, 4);
    write_reg(REG_COORDS, 3);
    hold_off = 1'b1;
    send_frames(6, 3, 1'b0);
    drain();
  endtask

  // Receiver: random stalls, plus one long counted hold-off.
  initial begin
    int stall_cycles;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        stall_cycles = 0;
        out_ready <= 1'b0;
        while (stall_cycles < 300) begin
          @(posedge clk);
          stall_cycles++;
        end
        hold_off = 1'b0;
      end
      out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  // Compares each accepted word with the oldest expectation.
  initial begin
    coded_word_t got, want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = '{out_is_residual, out_coded_value, out_coord_index, out_frame_last};
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", got);
        end else begin
          want = expected_words[0];
          expected_words.delete(0);
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected res=%0d val=%h idx=%0d last=%0d, got res=%0d val=%h idx=%0d last=%0d",
                       want.is_residual, want.coded_value, want.coord_index, want.frame_last,
                       got.is_residual, got.coded_value, got.coord_index, got.frame_last);
          end
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_coord_value = '0;
    mismatches = 0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hist_reg = HIST_RESET;
    win_reg = WINDOW_RESET;
    coords_reg = COORDS_RESET;
    restart_prediction();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle_pct = 14;
    recv_idle_pct = 87;
    test_random(0);
    send_idle_pct = 87;
    recv_idle_pct = 14;
    test_random(1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(2);
    test_backpressure();
    test_large_frame();
    drain();
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
